>>> rtl/sfts_pkg.sv
// sfts_pkg: command and result words, status codes and sequencer states
// for the strobe / frame time synchronizer; no dependencies
package sfts_pkg;

  typedef enum logic [1:0] {
    OP_PUSH_STROBE = 2'd0,
    OP_PUSH_FRAME  = 2'd1,
    OP_SYNC        = 2'd2,
    OP_QUERY       = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STS_OK             = 3'd0,
    STS_UNKNOWN_SENSOR = 3'd1,
    STS_FRAME_ABSENT   = 3'd2,
    STS_NO_STROBE      = 3'd3,
    STS_NOT_FULL       = 3'd4,
    STS_WEAK_VOTE      = 3'd5,
    STS_INCONSISTENT   = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  sensor;
    logic [31:0] count_value;
    logic [63:0] time_stamp;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [63:0]        matched_time;
    logic signed [31:0] offset_found;
  } result_word_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SY_START,
    S_SY_SENSOR,
    S_W_SREAD,
    S_W_SLATCH,
    S_W_FREAD,
    S_W_FDIST,
    S_W_FCMP,
    S_V_IREAD,
    S_V_ILATCH,
    S_V_JREAD,
    S_V_JCMP,
    S_V_BEST,
    S_V_DONE,
    S_SY_CONS,
    S_Q_FREAD,
    S_Q_FCMP,
    S_Q_SREAD,
    S_Q_SCMP
  } state_t;

endpackage

>>> rtl/sfts_ram.sv
// sfts_ram: single write port, single registered read port ram
// no package dependencies
module sfts_ram #(
  parameter int WIDTH   = 32,
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/strobe_frame_time_synchronizer.sv
// strobe_frame_time_synchronizer: strobe ring, per-sensor frame rings, offset vote
// depends on sfts_pkg and sfts_ram
// a push answers in the next cycle; a query steps through a read and a compare state
// for each ring entry read; a synchronize walks and votes each seen sensor in turn,
// paced by the frame and vote memory read ports and the shared distance compare.
// throughput: one command at a time, busy is high until the result strobe.
// reset clears ring heads, fill counts, sensor flags and offsets; the result is taken
// in the cycle done is high, the receiver cannot stall.
module strobe_frame_time_synchronizer #(
  parameter int DEPTH       = 16,
  parameter int NUM_SENSORS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  sfts_pkg::cmd_word_t   cmd,
  output logic                  done,
  output sfts_pkg::result_word_t result
);
  import sfts_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int SCW = $clog2(NUM_SENSORS + 1);
  localparam int FAW = $clog2(NUM_SENSORS * DEPTH);

  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] h, input logic [AW-1:0] k);
    logic [AW:0] sum;
    sum = {1'b0, h} + {1'b0, k};
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  function automatic logic [FAW-1:0] faddr(input logic [SW-1:0] s, input logic [AW-1:0] p);
    return FAW'(s) * FAW'(DEPTH) + FAW'(p);
  endfunction

  state_t state, state_next;

  logic [AW-1:0]  strobe_head;
  logic [CW-1:0]  strobe_fill;
  logic [AW-1:0]  frame_heads [NUM_SENSORS];
  logic [CW-1:0]  frame_fills [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] sensor_seen;
  logic [31:0]    sensor_offset [NUM_SENSORS];

  logic [SCW-1:0] sidx;
  logic [SW-1:0]  cur_s;
  logic [CW-1:0]  i, j, c, bc;
  logic [63:0]    st, fdist, last_dist;
  logic [31:0]    sc, off, last_off, vi, best, qv;

  logic [2:0]     status;
  logic [63:0]    mtime;
  logic [31:0]    offs;

  // ram ports
  logic           s_we, f_we, v_we;
  logic [AW-1:0]  s_waddr, s_raddr, v_raddr;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [95:0]    s_rdata, f_rdata;
  logic [31:0]    v_wdata, v_rdata;

  // decode of the incoming word
  logic           accept;
  logic [31:0]    sens_ext;
  logic [SW-1:0]  sens_idx;
  logic           sens_ok;
  assign accept   = start && !busy;
  assign sens_ext = 32'(cmd.sensor);
  assign sens_idx = sens_ext[SW-1:0];
  assign sens_ok  = sens_ext < 32'(NUM_SENSORS);

  // fullness check over the strobe ring and all seen sensors
  logic all_full;
  always_comb begin
    logic any;
    logic ok;
    any = 1'b0;
    ok  = (strobe_fill == CW'(DEPTH));
    for (int s = 0; s < NUM_SENSORS; s++) begin
      if (sensor_seen[s]) begin
        any = 1'b1;
        if (frame_fills[s] != CW'(DEPTH)) ok = 1'b0;
      end
    end
    all_full = ok && any;
  end

  // offset agreement over seen sensors
  logic mismatch;
  always_comb begin
    logic        have;
    logic [31:0] ref_off;
    have     = 1'b0;
    ref_off  = '0;
    mismatch = 1'b0;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      if (sensor_seen[s]) begin
        if (!have) begin
          ref_off = sensor_offset[s];
          have    = 1'b1;
        end else if (sensor_offset[s] != ref_off) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  logic [31:0] first_off;
  always_comb begin
    logic have;
    have      = 1'b0;
    first_off = '0;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      if (sensor_seen[s] && !have) begin
        first_off = sensor_offset[s];
        have      = 1'b1;
      end
    end
  end

  // distance compare and vote helpers
  logic grew, last_f, last_v, vote_ok, better, q_fmatch, q_smatch, q_fend, q_send;
  assign grew     = (j != '0) && (fdist > last_dist);
  assign last_f   = (j == CW'(DEPTH - 1));
  assign last_v   = (j == CW'(DEPTH - 3));
  assign vote_ok  = bc > CW'(DEPTH - 4);
  assign better   = (c > bc) || ((c == bc) && ($signed(vi) < $signed(best)));
  assign q_fend   = (j == frame_fills[cur_s]);
  assign q_send   = (j == strobe_fill);
  assign q_fmatch = (f_rdata[95:64] == qv);
  assign q_smatch = ((s_rdata[95:64] + sensor_offset[cur_s]) == qv);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.opcode == OP_SYNC) state_next = S_SY_START;
          else if (cmd.opcode == OP_QUERY && sens_ok && sensor_seen[sens_idx])
            state_next = S_Q_FREAD;
        end
      end
      S_SY_START:  state_next = all_full ? S_SY_SENSOR : S_IDLE;
      S_SY_SENSOR: begin
        if (sidx == SCW'(NUM_SENSORS)) state_next = S_SY_CONS;
        else if (sensor_seen[sidx[SW-1:0]]) state_next = S_W_SREAD;
      end
      S_W_SREAD:  state_next = S_W_SLATCH;
      S_W_SLATCH: state_next = S_W_FREAD;
      S_W_FREAD:  state_next = S_W_FDIST;
      S_W_FDIST:  state_next = S_W_FCMP;
      S_W_FCMP: begin
        if (grew || last_f) state_next = (i == CW'(DEPTH - 3)) ? S_V_IREAD : S_W_SREAD;
        else state_next = S_W_FREAD;
      end
      S_V_IREAD:  state_next = S_V_ILATCH;
      S_V_ILATCH: state_next = S_V_JREAD;
      S_V_JREAD:  state_next = S_V_JCMP;
      S_V_JCMP:   state_next = last_v ? S_V_BEST : S_V_JREAD;
      S_V_BEST:   state_next = (i == CW'(DEPTH - 3)) ? S_V_DONE : S_V_IREAD;
      S_V_DONE:   state_next = vote_ok ? S_SY_SENSOR : S_IDLE;
      S_SY_CONS:  state_next = S_IDLE;
      S_Q_FREAD:  state_next = q_fend ? S_IDLE : S_Q_FCMP;
      S_Q_FCMP:   state_next = q_fmatch ? S_Q_SREAD : S_Q_FREAD;
      S_Q_SREAD:  state_next = q_send ? S_IDLE : S_Q_SCMP;
      S_Q_SCMP:   state_next = q_smatch ? S_IDLE : S_Q_SREAD;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    busy    = (state != S_IDLE);
    s_we    = accept && (cmd.opcode == OP_PUSH_STROBE);
    s_waddr = (strobe_fill < CW'(DEPTH)) ? ring_pos(strobe_head, strobe_fill[AW-1:0])
                                          : strobe_head;
    f_we    = accept && (cmd.opcode == OP_PUSH_FRAME) && sens_ok;
    f_waddr = faddr(sens_idx, (frame_fills[sens_idx] < CW'(DEPTH)) ?
              ring_pos(frame_heads[sens_idx], frame_fills[sens_idx][AW-1:0]) :
              frame_heads[sens_idx]);
    s_raddr = ring_pos(strobe_head, (state == S_W_SREAD) ? i[AW-1:0] : j[AW-1:0]);
    f_raddr = faddr(cur_s, ring_pos(frame_heads[cur_s], j[AW-1:0]));
    v_we    = (state == S_W_FCMP) && (grew || last_f);
    v_wdata = grew ? last_off : 32'd0;
    v_raddr = (state == S_V_IREAD) ? i[AW-1:0] : j[AW-1:0];
  end

  sfts_ram #(.WIDTH(96), .ENTRIES(DEPTH), .AW(AW)) u_strobe_ram (
    .clk, .we(s_we), .waddr(s_waddr), .wdata({cmd.count_value, cmd.time_stamp}),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  sfts_ram #(.WIDTH(96), .ENTRIES(NUM_SENSORS * DEPTH), .AW(FAW)) u_frame_ram (
    .clk, .we(f_we), .waddr(f_waddr), .wdata({cmd.count_value, cmd.time_stamp}),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  sfts_ram #(.WIDTH(32), .ENTRIES(DEPTH - 2), .AW(AW)) u_vote_ram (
    .clk, .we(v_we), .waddr(i[AW-1:0]), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strobe_head <= '0;
      strobe_fill <= '0;
      sensor_seen <= '0;
      done        <= 1'b0;
      for (int s = 0; s < NUM_SENSORS; s++) begin
        frame_heads[s]   <= '0;
        frame_fills[s]   <= '0;
        sensor_offset[s] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.opcode)
              OP_PUSH_STROBE: begin
                done <= 1'b1;
                if (strobe_fill < CW'(DEPTH)) strobe_fill <= strobe_fill + 1'b1;
                else strobe_head <= ring_pos(strobe_head, AW'(1));
              end
              OP_PUSH_FRAME: begin
                done <= 1'b1;
                if (sens_ok) begin
                  sensor_seen[sens_idx] <= 1'b1;
                  if (frame_fills[sens_idx] < CW'(DEPTH))
                    frame_fills[sens_idx] <= frame_fills[sens_idx] + 1'b1;
                  else frame_heads[sens_idx] <= ring_pos(frame_heads[sens_idx], AW'(1));
                end
              end
              OP_QUERY: begin
                if (!(sens_ok && sensor_seen[sens_idx])) done <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SY_START: if (!all_full) done <= 1'b1;
        S_V_DONE: begin
          if (vote_ok) sensor_offset[cur_s] <= best;
          else done <= 1'b1;
        end
        S_SY_CONS: begin
          done <= 1'b1;
          if (mismatch) begin
            for (int s = 0; s < NUM_SENSORS; s++) begin
              if (sensor_seen[s]) sensor_offset[s] <= '0;
            end
          end
        end
        S_Q_FREAD: if (q_fend) done <= 1'b1;
        S_Q_SREAD: if (q_send) done <= 1'b1;
        S_Q_SCMP:  if (q_smatch) done <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qv    <= cmd.count_value;
        cur_s <= sens_idx;
        sidx  <= '0;
        j     <= '0;
        mtime <= '0;
        offs  <= '0;
        status <= (cmd.opcode == OP_PUSH_FRAME && !sens_ok) ? STS_UNKNOWN_SENSOR :
                  (cmd.opcode == OP_QUERY) ? STS_UNKNOWN_SENSOR : STS_OK;
      end
      S_SY_START: status <= STS_NOT_FULL;
      S_SY_SENSOR: begin
        if (sidx != SCW'(NUM_SENSORS)) begin
          if (sensor_seen[sidx[SW-1:0]]) begin
            cur_s <= sidx[SW-1:0];
            i     <= '0;
          end
          sidx <= sidx + 1'b1;
        end
      end
      S_W_SLATCH: begin
        st <= s_rdata[63:0];
        sc <= s_rdata[95:64];
        j  <= '0;
      end
      S_W_FDIST: begin
        fdist <= (f_rdata[63:0] > st) ? f_rdata[63:0] - st : st - f_rdata[63:0];
        off   <= f_rdata[95:64] - sc;
      end
      S_W_FCMP: begin
        if (grew || last_f) begin
          if (i == CW'(DEPTH - 3)) begin
            i    <= '0;
            best <= '0;
            bc   <= '0;
          end else begin
            i <= i + 1'b1;
          end
        end else begin
          last_dist <= fdist;
          last_off  <= off;
          j         <= j + 1'b1;
        end
      end
      S_V_ILATCH: begin
        vi <= v_rdata;
        j  <= '0;
        c  <= '0;
      end
      S_V_JCMP: begin
        if (v_rdata == vi) c <= c + 1'b1;
        if (!last_v) j <= j + 1'b1;
      end
      S_V_BEST: begin
        if (better) begin
          best <= vi;
          bc   <= c;
        end
        i <= i + 1'b1;
      end
      S_V_DONE: if (!vote_ok) status <= STS_WEAK_VOTE;
      S_SY_CONS: begin
        status <= mismatch ? STS_INCONSISTENT : STS_OK;
        offs   <= mismatch ? 32'd0 : first_off;
      end
      S_Q_FREAD: if (q_fend) status <= STS_FRAME_ABSENT;
      S_Q_FCMP:  j <= q_fmatch ? '0 : j + 1'b1;
      S_Q_SREAD: if (q_send) status <= STS_NO_STROBE;
      S_Q_SCMP: begin
        if (q_smatch) begin
          status <= STS_OK;
          mtime  <= s_rdata[63:0];
        end
        j <= j + 1'b1;
      end
      default: ;
    endcase
  end

  assign result.status       = status;
  assign result.matched_time = mtime;
  assign result.offset_found = $signed(offs);

  // result strobe only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a push answers in the next cycle
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd.opcode == OP_PUSH_STROBE || cmd.opcode == OP_PUSH_FRAME)) |=> done)
    else $error("push without result");

  // strobe ring fill never passes its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    strobe_fill <= CW'(DEPTH))
    else $error("strobe fill overflow");

  // a matched time is only reported on a good status
  a_time_ok: assert property (@(posedge clk) disable iff (rst)
    (done && mtime != '0) |-> (status == STS_OK))
    else $error("time with error status");

endmodule

>>> sim/strobe_frame_time_synchronizer_tb.sv
// strobe_frame_time_synchronizer_tb: drives push, synchronize and query words into the
// synchronizer and checks every result word against an in-bench ring and vote predictor
// depends on sfts_pkg and the strobe_frame_time_synchronizer rtl
`timescale 1ns / 100ps

module strobe_frame_time_synchronizer_tb;
  import sfts_pkg::*;

  localparam int DEPTH       = 16;
  localparam int NSENS       = 4;
  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int SETTLE      = 50;
  localparam int QDEPTH      = 4096;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         busy;
  cmd_word_t    cmd = '0;
  logic         done;
  result_word_t result;

  strobe_frame_time_synchronizer #(.DEPTH(DEPTH), .NUM_SENSORS(NSENS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] strobe_cnt [DEPTH];
  logic [63:0] strobe_tim [DEPTH];
  int          strobe_head, strobe_fill;
  logic [31:0] frame_num [NSENS][DEPTH];
  logic [63:0] frame_tim [NSENS][DEPTH];
  int          frame_head [NSENS];
  int          frame_fill [NSENS];
  bit          seen [NSENS];
  logic [31:0] sensor_off [NSENS];

  cmd_word_t    pending_words [QDEPTH];
  result_word_t expected_words [QDEPTH];
  int           pend_wr = 0;
  int           pend_rd = 0;
  int           exp_wr = 0;
  int           exp_rd = 0;
  int           errors = 0;
  int           total_words = 0;
  int           sent_words = 0;
  int           got_words = 0;
  int           cycles = 0;

  // distance-minimum walk and vote for one sensor
  function automatic bit vote_offset(int s, output logic [31:0] win);
    logic [31:0] votes [DEPTH];
    logic [31:0] best, off, last_off, sc;
    logic [63:0] fdist, last_dist, st, ft;
    int          best_cnt, c, sp, fp;
    best = 0;
    best_cnt = 0;
    win = 0;
    for (int i = 0; i < DEPTH - 2; i++) begin
      sp = (strobe_head + i) % DEPTH;
      st = strobe_tim[sp];
      sc = strobe_cnt[sp];
      fdist = 0;
      off = 0;
      votes[i] = 0;
      for (int j = 0; j < DEPTH; j++) begin
        fp = (frame_head[s] + j) % DEPTH;
        last_dist = fdist;
        last_off = off;
        ft = frame_tim[s][fp];
        fdist = (ft > st) ? ft - st : st - ft;
        off = frame_num[s][fp] - sc;
        if (j > 0 && fdist > last_dist) begin
          votes[i] = last_off;
          break;
        end
      end
    end
    for (int i = 0; i < DEPTH - 2; i++) begin
      c = 0;
      for (int j = 0; j < DEPTH - 2; j++)
        if (votes[j] == votes[i]) c++;
      if (c > best_cnt || (c == best_cnt && $signed(votes[i]) < $signed(best))) begin
        best = votes[i];
        best_cnt = c;
      end
    end
    if (best_cnt > DEPTH - 4) begin
      win = best;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_word_t sync_offsets();
    result_word_t r;
    logic [31:0]  w, ref_off;
    bit           any, first;
    r = '0;
    r.status = STS_OK;
    any = 0;
    if (strobe_fill < DEPTH) begin
      r.status = STS_NOT_FULL;
      return r;
    end
    for (int s = 0; s < NSENS; s++)
      if (seen[s]) begin
        any = 1;
        if (frame_fill[s] < DEPTH) begin
          r.status = STS_NOT_FULL;
          return r;
        end
      end
    if (!any) begin
      r.status = STS_NOT_FULL;
      return r;
    end
    for (int s = 0; s < NSENS; s++) begin
      if (!seen[s]) continue;
      if (!vote_offset(s, w)) begin
        r.status = STS_WEAK_VOTE;
        return r;
      end
      sensor_off[s] = w;
    end
    first = 1;
    ref_off = 0;
    for (int s = 0; s < NSENS; s++) begin
      if (!seen[s]) continue;
      if (first) begin
        ref_off = sensor_off[s];
        first = 0;
      end else if (sensor_off[s] != ref_off) begin
        for (int k = 0; k < NSENS; k++)
          if (seen[k]) sensor_off[k] = 0;
        r.status = STS_INCONSISTENT;
        return r;
      end
    end
    r.offset_found = ref_off;
    return r;
  endfunction

  function automatic result_word_t lookup_time(int s, logic [31:0] fnum);
    result_word_t r;
    bit           found;
    int           p;
    r = '0;
    found = 0;
    if (!seen[s]) begin
      r.status = STS_UNKNOWN_SENSOR;
      return r;
    end
    for (int k = 0; k < frame_fill[s]; k++)
      if (frame_num[s][(frame_head[s] + k) % DEPTH] == fnum) found = 1;
    if (!found) begin
      r.status = STS_FRAME_ABSENT;
      return r;
    end
    for (int k = 0; k < strobe_fill; k++) begin
      p = (strobe_head + k) % DEPTH;
      if (strobe_cnt[p] + sensor_off[s] == fnum) begin
        r.status = STS_OK;
        r.matched_time = strobe_tim[p];
        return r;
      end
    end
    r.status = STS_NO_STROBE;
    return r;
  endfunction

  // applies one command word to the predictor and returns its result word
  function automatic result_word_t apply_word(cmd_word_t c);
    result_word_t r;
    int           p, s;
    r = '0;
    s = c.sensor;
    case (opcode_t'(c.opcode))
      OP_PUSH_STROBE: begin
        if (strobe_fill < DEPTH) begin
          p = (strobe_head + strobe_fill) % DEPTH;
          strobe_fill++;
        end else begin
          p = strobe_head;
          strobe_head = (strobe_head + 1) % DEPTH;
        end
        strobe_cnt[p] = c.count_value;
        strobe_tim[p] = c.time_stamp;
        r.status = STS_OK;
      end
      OP_PUSH_FRAME: begin
        if (frame_fill[s] < DEPTH) begin
          p = (frame_head[s] + frame_fill[s]) % DEPTH;
          frame_fill[s]++;
        end else begin
          p = frame_head[s];
          frame_head[s] = (frame_head[s] + 1) % DEPTH;
        end
        frame_num[s][p] = c.count_value;
        frame_tim[s][p] = c.time_stamp;
        seen[s] = 1;
        r.status = STS_OK;
      end
      OP_SYNC:  r = sync_offsets();
      default:  r = lookup_time(s, c.count_value);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
    errors++;
  endtask

  task automatic add_word(opcode_t op, int s, logic [31:0] cv, logic [63:0] ts);
    cmd_word_t c;
    c.opcode = op;
    c.sensor = s[1:0];
    c.count_value = cv;
    c.time_stamp = ts;
    pending_words[pend_wr] = c;
    pend_wr++;
  endtask

  // one capture episode: strobes and frames on all sensors, then sync and queries
  // kind 0 aligned, 1 one sensor off by a different offset, 2 scrambled frame times
  task automatic add_episode(int kind, bit top_of_range);
    logic [31:0] cb, soff;
    logic [31:0] offs [NSENS];
    logic [63:0] tb, per, t;
    int          n;
    cb = $urandom;
    per = $urandom_range(1000, 1_000_000);
    tb = top_of_range ? 64'hFFFF_FFFF_FFFF_FFFF - 20 * per : {$urandom, $urandom} >> 1;
    soff = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6) - 3;
    foreach (offs[s]) offs[s] = soff;
    if (kind == 1) offs[$urandom_range(0, NSENS - 1)] = soff + $urandom_range(1, 3);
    n = DEPTH + $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      add_word(OP_PUSH_STROBE, $urandom_range(0, 3), cb + k,
               tb + k * per + $urandom_range(0, per / 8));
      for (int s = 0; s < NSENS; s++) begin
        t = (kind == 2) ? {$urandom, $urandom} : tb + k * per + $urandom_range(0, per / 8);
        add_word(OP_PUSH_FRAME, s, cb + k + offs[s], t);
      end
    end
    add_word(OP_SYNC, $urandom_range(0, 3), $urandom, {$urandom, $urandom});
    for (int q = 0; q < 6; q++) begin
      int s;
      s = $urandom_range(0, NSENS - 1);
      if ($urandom_range(0, 4) == 0)
        add_word(OP_QUERY, s, $urandom, {$urandom, $urandom});
      else
        add_word(OP_QUERY, s, cb + $urandom_range(0, n + 2) + offs[s], {$urandom, $urandom});
    end
  endtask

  // driver: hands out pending words, idling by phase
  always @(posedge clk) begin
    int  idle_pct;
    bit  go;
    cmd_word_t nxt;
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      nxt = cmd;
      if (start && !busy) begin
        expected_words[exp_wr] = apply_word(cmd);
        exp_wr++;
      end
      if (start && busy) begin
        go = 1'b1;
      end else if (pend_rd < pend_wr) begin
        idle_pct = (sent_words * 3 < total_words) ? 9 :
                   (sent_words * 3 < total_words * 2) ? 66 : 0;
        if ($urandom_range(0, 99) >= idle_pct) begin
          go = 1'b1;
          nxt = pending_words[pend_rd];
          pend_rd++;
          sent_words++;
        end
      end
      start <= go;
      cmd <= nxt;
    end
  end

  // monitor: compares each result word with the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && done) begin
      got_words++;
      if (exp_rd == exp_wr) begin
        $display("unexpected result word at cycle %0d", cycles);
        errors++;
      end else begin
        want = expected_words[exp_rd];
        exp_rd++;
        if (result.status !== want.status)
          report_mismatch("status", 64'(result.status), 64'(want.status));
        if (result.matched_time !== want.matched_time)
          report_mismatch("matched_time", result.matched_time, want.matched_time);
        if (result.offset_found !== want.offset_found)
          report_mismatch("offset_found", 64'(result.offset_found), 64'(want.offset_found));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("strobe_frame_time_synchronizer verification failed");
      $finish;
    end
  end

  initial begin
    int ep;
    strobe_head = 0;
    strobe_fill = 0;
    foreach (seen[s]) begin
      seen[s] = 0;
      sensor_off[s] = 0;
      frame_head[s] = 0;
      frame_fill[s] = 0;
    end

    // directed: empty state, extreme values, each query outcome
    add_word(OP_QUERY, 0, 32'd0, 64'd0);
    add_word(OP_SYNC, 0, 32'd0, 64'd0);
    add_word(OP_PUSH_FRAME, 0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_PUSH_STROBE, 3, 32'd0, 64'd0);
    add_word(OP_QUERY, 0, 32'd0, 64'd0);
    add_word(OP_QUERY, 0, 32'hFFFF_FFFF, 64'd0);
    add_word(OP_PUSH_STROBE, 0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_QUERY, 0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_SYNC, 0, 32'd0, 64'd0);
    add_word(OP_QUERY, 1, 32'hFFFF_FFFF, 64'd0);
    add_word(OP_QUERY, 3, 32'd0, 64'd0);

    // episodes of well-formed captures with some noise in between
    ep = 0;
    while (pend_wr < 1250) begin
      add_episode((ep % 5 == 3) ? 1 : (ep % 5 == 4) ? 2 : 0, ep == 1);
      for (int k = 0; k < 8; k++)
        add_word(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom,
                 {$urandom, $urandom});
      ep++;
    end
    total_words = pend_wr;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // wait for one result word per command word, then let the block settle
    do @(posedge clk);
    while (got_words < total_words);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("strobe_frame_time_synchronizer verification clean");
    end else begin
      $display("strobe_frame_time_synchronizer verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sfts_pkg.sv
rtl/sfts_ram.sv
rtl/strobe_frame_time_synchronizer.sv
sim/strobe_frame_time_synchronizer_tb.sv
